>>> design/line_rasterizer_defines.svh
// line_rasterizer_defines.svh: assertion macros used by the rasterizer top level
// no dependencies; include by bare file name
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lr_pkg.sv
// lr_pkg: types and fixed constants of the line rasterizer
// no dependencies; imported by every rasterizer module
package lr_pkg;

    localparam int COORD_BITS = 6;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 4;
    localparam int MODE_BITS  = 2;
    localparam int Q_DEPTH    = 2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CNT_BITS-1:0]   t_count;
    typedef logic [MODE_BITS-1:0]  t_mode;

    // algorithm codes of the mode register; the unused code runs classic
    typedef enum logic [MODE_BITS-1:0] {
        ALGO_DDA     = 2'd0,
        ALGO_MID     = 2'd1,
        ALGO_CLASSIC = 2'd2
    } t_algo;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg_in;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_pix_out;

    // classified line handed from front to back
    typedef struct packed {
        t_algo  algo;
        logic   empty_line;
        t_coord start_x;
        t_coord start_y;
        t_coord dx_mag;
        t_coord dy_mag;
        logic   x_neg;
        logic   y_neg;
        logic   steep;
        t_count count;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    typedef struct packed {
        logic idle;
        logic pop;
    } t_back_st;

endpackage

>>> design/lr_front.sv
// lr_front: classifies a segment request into a walk command
// depends on lr_pkg
module lr_front (
    input  lr_pkg::t_seg_in i_seg,
    input  lr_pkg::t_mode   i_mode,
    output lr_pkg::t_cmd    o_cmd
);
    import lr_pkg::*;

    t_coord w_adx;
    t_coord w_ady;
    logic   w_xneg;
    logic   w_yneg;
    t_coord w_eps;
    logic   w_swap;
    t_coord w_lx;
    t_coord w_ly;
    t_coord w_rx;
    t_coord w_ry;
    t_coord w_bdx;
    t_coord w_bady;
    logic   w_bneg;
    logic   w_bsteep;

    // dda deltas from start toward end
    assign w_xneg = i_seg.end_x < i_seg.start_x;
    assign w_yneg = i_seg.end_y < i_seg.start_y;
    assign w_adx  = w_xneg ? (i_seg.start_x - i_seg.end_x) : (i_seg.end_x - i_seg.start_x);
    assign w_ady  = w_yneg ? (i_seg.start_y - i_seg.end_y) : (i_seg.end_y - i_seg.start_y);
    assign w_eps  = (w_adx > w_ady) ? w_adx : w_ady;

    // bresenham walks from the left endpoint
    assign w_swap   = i_seg.start_x > i_seg.end_x;
    assign w_lx     = w_swap ? i_seg.end_x   : i_seg.start_x;
    assign w_ly     = w_swap ? i_seg.end_y   : i_seg.start_y;
    assign w_rx     = w_swap ? i_seg.start_x : i_seg.end_x;
    assign w_ry     = w_swap ? i_seg.start_y : i_seg.end_y;
    assign w_bdx    = w_rx - w_lx;
    assign w_bneg   = w_ry < w_ly;
    assign w_bady   = w_bneg ? (w_ly - w_ry) : (w_ry - w_ly);
    assign w_bsteep = !(w_bdx > w_bady);

    // command build per algorithm
    always_comb begin
        o_cmd.algo       = ALGO_CLASSIC;
        o_cmd.empty_line = 1'b0;
        o_cmd.start_x    = w_lx;
        o_cmd.start_y    = w_ly;
        o_cmd.dx_mag     = w_bdx;
        o_cmd.dy_mag     = w_bady;
        o_cmd.x_neg      = 1'b0;
        o_cmd.y_neg      = w_bneg;
        o_cmd.steep      = w_bsteep;
        o_cmd.count      = CNT_BITS'(w_bsteep ? w_bady : w_bdx) + CNT_BITS'(1);
        case (i_mode)
            ALGO_DDA: begin
                o_cmd.algo       = ALGO_DDA;
                o_cmd.empty_line = (w_eps == '0);
                o_cmd.start_x    = i_seg.start_x;
                o_cmd.start_y    = i_seg.start_y;
                o_cmd.dx_mag     = w_adx;
                o_cmd.dy_mag     = w_ady;
                o_cmd.x_neg      = w_xneg;
                o_cmd.y_neg      = w_yneg;
                o_cmd.steep      = 1'b0;
                o_cmd.count      = CNT_BITS'(w_eps);
            end
            ALGO_MID: begin
                o_cmd.algo = ALGO_MID;
            end
            default: begin
                o_cmd.algo = ALGO_CLASSIC;
            end
        endcase
    end

endmodule

>>> design/lr_cmd_fifo.sv
// lr_cmd_fifo: short command queue between front and back
// depends on lr_pkg
module lr_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lr_pkg::t_cmd     i_cmd,
    input  logic             i_pop,
    output lr_pkg::t_cmd     o_cmd,
    output lr_pkg::t_fifo_st o_st
);
    import lr_pkg::*;

    localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int LVL_BITS = $clog2(Q_DEPTH + 1);

    t_cmd                r_slot [Q_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [LVL_BITS-1:0] r_level;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [LVL_BITS-1:0] n_level;

    assign o_cmd      = r_slot[r_rd_ptr];
    assign o_st.full  = (r_level == LVL_BITS'(Q_DEPTH));
    assign o_st.empty = (r_level == '0);

    // pointer wrap and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_level = r_level + LVL_BITS'(1);
            2'b01:   n_level = r_level - LVL_BITS'(1);
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/lr_back.sv
// lr_back: walks one command at a time, bit-serial divide for dda steps
// depends on lr_pkg
module lr_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lr_pkg::t_cmd     i_cmd,
    input  logic             i_q_empty,
    output lr_pkg::t_back_st o_st,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lr_pkg::t_pix_out o_out_data
);
    import lr_pkg::*;

    localparam int NUM_BITS  = COORD_BITS + FRAC_BITS + 1;
    localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam int DCNT_BITS = $clog2(NUM_BITS + 1);
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state                r_state,    n_state;
    t_algo                 r_algo,     n_algo;
    logic                  r_steep,    n_steep;
    logic                  r_x_neg,    n_x_neg;
    logic                  r_y_neg,    n_y_neg;
    t_coord                r_dx_mag,   n_dx_mag;
    t_coord                r_dy_mag,   n_dy_mag;
    t_count                r_count,    n_count;
    logic [COORD_BITS:0]   r_pos_x,    n_pos_x;
    logic [COORD_BITS:0]   r_pos_y,    n_pos_y;
    logic [ERR_BITS-1:0]   r_err,      n_err;
    logic [ACC_BITS-1:0]   r_acc_x,    n_acc_x;
    logic [ACC_BITS-1:0]   r_acc_y,    n_acc_y;
    logic [NUM_BITS-1:0]   r_num_x,    n_num_x;
    logic [NUM_BITS-1:0]   r_num_y,    n_num_y;
    t_coord                r_rem_x,    n_rem_x;
    t_coord                r_rem_y,    n_rem_y;
    t_coord                r_den,      n_den;
    logic [DCNT_BITS-1:0]  r_div_cnt,  n_div_cnt;
    logic                  r_out_valid, n_out_valid;
    t_pix_out              r_out,      n_out;

    logic                  w_adv;
    logic                  w_pop;
    logic                  w_last;
    // divider step
    logic [COORD_BITS:0]   w_try_x;
    logic [COORD_BITS:0]   w_try_y;
    logic [COORD_BITS:0]   w_dif_x;
    logic [COORD_BITS:0]   w_dif_y;
    logic                  w_ge_x;
    logic                  w_ge_y;
    // dda pixel and increments
    logic [ACC_BITS-1:0]   w_fx;
    logic [ACC_BITS-1:0]   w_fy;
    t_coord                w_dda_x;
    t_coord                w_dda_y;
    logic [ACC_BITS-1:0]   w_qx;
    logic [ACC_BITS-1:0]   w_qy;
    logic [ACC_BITS-1:0]   w_inc_x;
    logic [ACC_BITS-1:0]   w_inc_y;
    // bresenham decision
    t_coord                w_maj;
    t_coord                w_min;
    logic [ERR_BITS-1:0]   w_two_a;
    logic [ERR_BITS-1:0]   w_two_b;
    logic [ERR_BITS-1:0]   w_cls_t;
    logic                  w_minor;
    logic [ERR_BITS-1:0]   w_err_next;
    logic [COORD_BITS:0]   w_y_dir;
    t_coord                w_cmaj;
    t_coord                w_cmin;
    logic [ERR_BITS-1:0]   w_init_mid;
    logic [ERR_BITS-1:0]   w_init_cls;

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_last = (r_count == CNT_BITS'(1));

    // restoring divide, one quotient bit per cycle on each axis
    assign w_try_x = {r_rem_x, r_num_x[NUM_BITS-1]};
    assign w_try_y = {r_rem_y, r_num_y[NUM_BITS-1]};
    assign w_dif_x = w_try_x - {1'b0, r_den};
    assign w_dif_y = w_try_y - {1'b0, r_den};
    assign w_ge_x  = w_try_x >= {1'b0, r_den};
    assign w_ge_y  = w_try_y >= {1'b0, r_den};

    // dda pixel, halves round up, negatives clamp to zero
    assign w_fx    = r_acc_x + HALF;
    assign w_fy    = r_acc_y + HALF;
    assign w_dda_x = w_fx[ACC_BITS-1] ? '0 : w_fx[FRAC_BITS +: COORD_BITS];
    assign w_dda_y = w_fy[ACC_BITS-1] ? '0 : w_fy[FRAC_BITS +: COORD_BITS];
    assign w_qx    = ACC_BITS'(r_num_x[Q_BITS-1:0]);
    assign w_qy    = ACC_BITS'(r_num_y[Q_BITS-1:0]);
    assign w_inc_x = r_x_neg ? ('0 - w_qx) : w_qx;
    assign w_inc_y = r_y_neg ? ('0 - w_qy) : w_qy;

    // bresenham error update over major and minor axes
    assign w_maj   = r_steep ? r_dy_mag : r_dx_mag;
    assign w_min   = r_steep ? r_dx_mag : r_dy_mag;
    assign w_two_a = ERR_BITS'({w_maj, 1'b0});
    assign w_two_b = ERR_BITS'({w_min, 1'b0});
    assign w_cls_t = r_err + w_two_b;
    always_comb begin
        if (r_algo == ALGO_MID) begin
            w_minor    = r_err[ERR_BITS-1];
            w_err_next = w_minor ? (r_err + w_two_a - w_two_b) : (r_err - w_two_b);
        end else begin
            w_minor    = !w_cls_t[ERR_BITS-1] && (w_cls_t != '0);
            w_err_next = w_minor ? (w_cls_t - w_two_a) : w_cls_t;
        end
    end
    assign w_y_dir = r_y_neg ? (r_pos_y - (COORD_BITS+1)'(1)) : (r_pos_y + (COORD_BITS+1)'(1));

    // starting decision value
    assign w_cmaj     = i_cmd.steep ? i_cmd.dy_mag : i_cmd.dx_mag;
    assign w_cmin     = i_cmd.steep ? i_cmd.dx_mag : i_cmd.dy_mag;
    assign w_init_mid = ERR_BITS'(w_cmaj) - ERR_BITS'({w_cmin, 1'b0});
    assign w_init_cls = '0 - ERR_BITS'(w_cmaj);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_algo      = r_algo;
        n_steep     = r_steep;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        n_dx_mag    = r_dx_mag;
        n_dy_mag    = r_dy_mag;
        n_count     = r_count;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_err       = r_err;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_num_x     = r_num_x;
        n_num_y     = r_num_y;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_den       = r_den;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    w_pop    = 1'b1;
                    n_algo   = i_cmd.algo;
                    n_steep  = i_cmd.steep;
                    n_x_neg  = i_cmd.x_neg;
                    n_y_neg  = i_cmd.y_neg;
                    n_dx_mag = i_cmd.dx_mag;
                    n_dy_mag = i_cmd.dy_mag;
                    n_count  = i_cmd.count;
                    n_pos_x  = {1'b0, i_cmd.start_x};
                    n_pos_y  = {1'b0, i_cmd.start_y};
                    n_err    = (i_cmd.algo == ALGO_MID) ? w_init_mid : w_init_cls;
                    n_acc_x  = {2'b00, i_cmd.start_x, {FRAC_BITS{1'b0}}};
                    n_acc_y  = {2'b00, i_cmd.start_y, {FRAC_BITS{1'b0}}};
                    n_num_x  = (NUM_BITS'(i_cmd.dx_mag) << FRAC_BITS)
                             + NUM_BITS'(i_cmd.count[CNT_BITS-1:1]);
                    n_num_y  = (NUM_BITS'(i_cmd.dy_mag) << FRAC_BITS)
                             + NUM_BITS'(i_cmd.count[CNT_BITS-1:1]);
                    n_rem_x  = '0;
                    n_rem_y  = '0;
                    n_den    = i_cmd.count[COORD_BITS-1:0];
                    n_div_cnt = DCNT_BITS'(NUM_BITS);
                    if (i_cmd.empty_line) begin
                        n_state = S_IDLE;
                    end else if (i_cmd.algo == ALGO_DDA) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_DIV: begin
                n_rem_x   = w_ge_x ? w_dif_x[COORD_BITS-1:0] : w_try_x[COORD_BITS-1:0];
                n_rem_y   = w_ge_y ? w_dif_y[COORD_BITS-1:0] : w_try_y[COORD_BITS-1:0];
                n_num_x   = {r_num_x[NUM_BITS-2:0], w_ge_x};
                n_num_y   = {r_num_y[NUM_BITS-2:0], w_ge_y};
                n_div_cnt = r_div_cnt - DCNT_BITS'(1);
                if (r_div_cnt == DCNT_BITS'(1)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_adv) begin
                    n_out_valid      = 1'b1;
                    n_out.last_pixel = w_last;
                    n_count          = r_count - CNT_BITS'(1);
                    if (r_algo == ALGO_DDA) begin
                        n_out.pixel_x = w_dda_x;
                        n_out.pixel_y = w_dda_y;
                        n_acc_x       = r_acc_x + w_inc_x;
                        n_acc_y       = r_acc_y + w_inc_y;
                    end else begin
                        n_out.pixel_x = r_pos_x[COORD_BITS-1:0];
                        n_out.pixel_y = r_pos_y[COORD_BITS-1:0];
                        n_err         = w_err_next;
                        if (r_steep) begin
                            n_pos_y = w_y_dir;
                            n_pos_x = w_minor ? (r_pos_x + (COORD_BITS+1)'(1)) : r_pos_x;
                        end else begin
                            n_pos_x = r_pos_x + (COORD_BITS+1)'(1);
                            n_pos_y = w_minor ? w_y_dir : r_pos_y;
                        end
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_algo    <= n_algo;
        r_steep   <= n_steep;
        r_x_neg   <= n_x_neg;
        r_y_neg   <= n_y_neg;
        r_dx_mag  <= n_dx_mag;
        r_dy_mag  <= n_dy_mag;
        r_count   <= n_count;
        r_pos_x   <= n_pos_x;
        r_pos_y   <= n_pos_y;
        r_err     <= n_err;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_num_x   <= n_num_x;
        r_num_y   <= n_num_y;
        r_rem_x   <= n_rem_x;
        r_rem_y   <= n_rem_y;
        r_den     <= n_den;
        r_div_cnt <= n_div_cnt;
        r_out     <= n_out;
    end

    assign o_st.idle   = (r_state == S_IDLE);
    assign o_st.pop    = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/line_rasterizer.sv
// line_rasterizer: top level, mode register, front classifier, queue and walker
// depends on lr_pkg, lr_front, lr_cmd_fifo, lr_back and line_rasterizer_defines.svh
// flow: a request is queued, then the idle walker pops it and walks the line out pixel by pixel
// throughput: one pixel per cycle from the walker while i_out_ready does not stall the output;
// each line passes the idle state, dda lines also the bit-serial divide; a zero-length dda line emits no pixel
// reset: synchronous active low, empties queue and walker, mode returns to dda
`include "line_rasterizer_defines.svh"
module line_rasterizer #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  lr_pkg::t_mode    i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lr_pkg::t_seg_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lr_pkg::t_pix_out o_out_data
);
    import lr_pkg::*;

    t_mode    r_mode;
    t_cmd     w_front_cmd;
    t_cmd     w_q_head;
    t_fifo_st w_q_st;
    t_back_st w_back_st;
    logic     w_q_push;

    // mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ALGO_DDA;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // front: classify the request
    lr_front u_front (
        .i_seg  (i_in_data),
        .i_mode (r_mode),
        .o_cmd  (w_front_cmd)
    );

    assign o_in_ready = !w_q_st.full;
    assign w_q_push   = i_in_valid && o_in_ready;

    // command queue
    lr_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_back_st.pop),
        .o_cmd   (w_q_head),
        .o_st    (w_q_st)
    );

    // back: divide and walk
    lr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_head),
        .i_q_empty   (w_q_st.empty),
        .o_st        (w_back_st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // checks
    `LR_ASSERT_NOW(a_pop_needs_cmd, i_clk, i_rst_n, w_back_st.pop, !w_q_st.empty, "pop from empty queue")
    `LR_ASSERT_NOW(a_idle_takes_cmd, i_clk, i_rst_n, w_back_st.idle && !w_q_st.empty, w_back_st.pop, "idle walker left a command waiting")
    `LR_ASSERT_NEXT(a_pop_starts_walk, i_clk, i_rst_n, w_back_st.pop && !w_q_head.empty_line, !w_back_st.idle, "popped line did not start")

endmodule
